// ----- rtl/gpip_pkg.sv -----
// Shared types, widths and constants for the ground point to image projection block.
// Used by gpip_front, gpip_div, gpip_back and the top level; depends on nothing.
`default_nettype none

package gpip_pkg;

   // Port field widths
   localparam int CFG_W     = 16;
   localparam int REG_IDX_W = 3;
   localparam int IN_W      = 24;
   localparam int OUT_W     = 24;

   // Datapath widths
   localparam int DX_W       = 25;   // ground_fwd - camera_offset, also -ground_left
   localparam int DEPTH_W    = 42;   // depth and down, Q14 * 1/1024 m, signed
   localparam int DEP_W      = 41;   // depth as a positive divisor
   localparam int DOWN_SPLIT = 21;   // low slice of down for the split row product
   localparam int NUM_W      = 59;   // signed dividends
   localparam int REM_W      = 59;   // dividend magnitude plus half divisor
   localparam int QUO_W      = 25;   // quotient bits kept; larger quotients saturate
   localparam int CMP_W      = DEP_W + QUO_W;
   localparam int SUM_W      = 27;   // center plus signed quotient
   localparam int Q14_SHIFT  = 14;

   localparam int LANES    = 2;
   localparam int LANE_COL = 0;
   localparam int LANE_ROW = 1;

   localparam int Q14_ONE         = 16384;
   localparam int MIN_DEPTH_UNITS = 1;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-8388608);

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PITCH_SIN     = 3'd0,
      REG_PITCH_COS     = 3'd1,
      REG_FOCAL_X       = 3'd2,
      REG_FOCAL_Y       = 3'd3,
      REG_CENTER_X      = 3'd4,
      REG_CENTER_Y      = 3'd5,
      REG_CAMERA_HEIGHT = 3'd6,
      REG_CAMERA_OFFSET = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] pitch_sin;
      logic signed [CFG_W-1:0] pitch_cos;
      logic [CFG_W-1:0]        focal_x;
      logic [CFG_W-1:0]        focal_y;
      logic [CFG_W-1:0]        center_x;
      logic [CFG_W-1:0]        center_y;
      logic [CFG_W-1:0]        camera_height;
      logic signed [CFG_W-1:0] camera_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pitch_sin:     16'sd0,
      pitch_cos:     16'sd16384,
      focal_x:       16'd16000,
      focal_y:       16'd16000,
      center_x:      16'd5120,
      center_y:      16'd3840,
      camera_height: 16'd1024,
      camera_offset: 16'sd0
   };

   // Sideband that travels with each point through the divider
   typedef struct packed {
      logic              ok;
      logic [LANES-1:0]  neg;
      logic [DEP_W-1:0]  den;
   } div_side_type;

endpackage

`default_nettype wire

// ----- rtl/gpip_front.sv -----
// Geometry front end: camera frame transform, depth test and dividend preparation.
// Seven register stages; depends on gpip_pkg.
`default_nettype none

module gpip_front #(
   parameter int MIN_DEPTH_UNITS = gpip_pkg::MIN_DEPTH_UNITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  gpip_pkg::cfg_type                         cfg,
   input  logic                                      in_valid,
   input  logic signed [gpip_pkg::IN_W-1:0]          in_fwd,
   input  logic signed [gpip_pkg::IN_W-1:0]          in_left,
   output logic                                      out_valid,
   output gpip_pkg::div_side_type                    out_side,
   output logic [gpip_pkg::LANES-1:0][gpip_pkg::REM_W-1:0] out_rem
);
   import gpip_pkg::*;

   localparam int STAGES = 7;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(MIN_DEPTH_UNITS * Q14_ONE);

   logic [STAGES-1:0] v_ff, v_in;

   // stage 1
   logic signed [DX_W-1:0] s1_dx_ff, s1_dx_in;
   logic signed [DX_W-1:0] s1_right_ff, s1_right_in;
   // stage 2
   logic signed [40:0] s2_dc_ff, s2_dc_in;
   logic signed [32:0] s2_hs_ff, s2_hs_in;
   logic signed [32:0] s2_hc_ff, s2_hc_in;
   logic signed [40:0] s2_ds_ff, s2_ds_in;
   logic signed [41:0] s2_fr_ff, s2_fr_in;
   // stage 3
   logic signed [DEPTH_W-1:0] s3_depth_ff, s3_depth_in;
   logic signed [DEPTH_W-1:0] s3_down_ff, s3_down_in;
   logic signed [41:0]        s3_fr_ff;
   logic                      s3_ok_ff, s3_ok_in;
   // stage 4
   logic [DEP_W-1:0]           s4_den_ff, s4_den_in;
   logic                       s4_ok_ff;
   logic [36:0]                s4_lo_ff, s4_lo_in;
   logic signed [37:0]         s4_hi_ff, s4_hi_in;
   logic signed [NUM_W-1:0]    s4_col_ff, s4_col_in;
   // stage 5
   logic [DEP_W-1:0]           s5_den_ff;
   logic                       s5_ok_ff;
   logic signed [NUM_W-1:0]    s5_col_ff;
   logic signed [NUM_W-1:0]    s5_row_ff, s5_row_in;
   // stage 6
   logic [DEP_W-1:0]              s6_den_ff;
   logic                          s6_ok_ff;
   logic [LANES-1:0]              s6_neg_ff, s6_neg_in;
   logic [LANES-1:0][NUM_W-1:0]   s6_mag_ff, s6_mag_in;
   // stage 7
   logic [DEP_W-1:0]              s7_den_ff;
   logic                          s7_ok_ff;
   logic [LANES-1:0]              s7_neg_ff;
   logic [LANES-1:0][REM_W-1:0]   s7_rem_ff, s7_rem_in;

   logic signed [NUM_W-1:0] num6 [LANES];

   assign v_in = {v_ff[STAGES-2:0], in_valid};

   assign s1_dx_in    = DX_W'(in_fwd) - DX_W'(cfg.camera_offset);
   assign s1_right_in = -DX_W'(in_left);

   assign s2_dc_in = s1_dx_ff * cfg.pitch_cos;
   assign s2_hs_in = $signed({1'b0, cfg.camera_height}) * cfg.pitch_sin;
   assign s2_hc_in = $signed({1'b0, cfg.camera_height}) * cfg.pitch_cos;
   assign s2_ds_in = s1_dx_ff * cfg.pitch_sin;
   assign s2_fr_in = $signed({1'b0, cfg.focal_x}) * s1_right_ff;

   assign s3_depth_in = DEPTH_W'(s2_dc_ff) + DEPTH_W'(s2_hs_ff);
   assign s3_down_in  = DEPTH_W'(s2_hc_ff) - DEPTH_W'(s2_ds_ff);
   assign s3_ok_in    = s3_depth_in >= DEPTH_MIN;

   // split focal_y * down into two narrow products, recombined next stage
   assign s4_den_in = s3_depth_ff[DEP_W-1:0];
   assign s4_lo_in  = cfg.focal_y * s3_down_ff[DOWN_SPLIT-1:0];
   assign s4_hi_in  = $signed({1'b0, cfg.focal_y}) * $signed(s3_down_ff[DEPTH_W-1:DOWN_SPLIT]);
   assign s4_col_in = NUM_W'(s3_fr_ff) <<< Q14_SHIFT;

   assign s5_row_in = $signed({s4_hi_ff, {DOWN_SPLIT{1'b0}}}) + $signed(NUM_W'(s4_lo_ff));

   always_comb begin
      num6[LANE_COL] = s5_col_ff;
      num6[LANE_ROW] = s5_row_ff;
      for (int l = 0; l < LANES; l++) begin
         s6_neg_in[l] = num6[l][NUM_W-1];
         s6_mag_in[l] = s6_neg_in[l] ? NUM_W'(-num6[l]) : NUM_W'(num6[l]);
      end
   end

   // bias by half the divisor for round-to-nearest, ties away from zero
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s7_rem_in[l] = REM_W'(s6_mag_ff[l]) + REM_W'(s6_den_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff    <= s1_dx_in;
         s1_right_ff <= s1_right_in;

         s2_dc_ff <= s2_dc_in;
         s2_hs_ff <= s2_hs_in;
         s2_hc_ff <= s2_hc_in;
         s2_ds_ff <= s2_ds_in;
         s2_fr_ff <= s2_fr_in;

         s3_depth_ff <= s3_depth_in;
         s3_down_ff  <= s3_down_in;
         s3_fr_ff    <= s2_fr_ff;
         s3_ok_ff    <= s3_ok_in;

         s4_den_ff <= s4_den_in;
         s4_ok_ff  <= s3_ok_ff;
         s4_lo_ff  <= s4_lo_in;
         s4_hi_ff  <= s4_hi_in;
         s4_col_ff <= s4_col_in;

         s5_den_ff <= s4_den_ff;
         s5_ok_ff  <= s4_ok_ff;
         s5_col_ff <= s4_col_ff;
         s5_row_ff <= s5_row_in;

         s6_den_ff <= s5_den_ff;
         s6_ok_ff  <= s5_ok_ff;
         s6_neg_ff <= s6_neg_in;
         s6_mag_ff <= s6_mag_in;

         s7_den_ff <= s6_den_ff;
         s7_ok_ff  <= s6_ok_ff;
         s7_neg_ff <= s6_neg_ff;
         s7_rem_ff <= s7_rem_in;
      end
   end

   assign out_valid    = v_ff[STAGES-1];
   assign out_side.ok  = s7_ok_ff;
   assign out_side.neg = s7_neg_ff;
   assign out_side.den = s7_den_ff;
   assign out_rem      = s7_rem_ff;

endmodule

`default_nettype wire

// ----- rtl/gpip_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// First stage flags quotients that do not fit; depends on gpip_pkg.
`default_nettype none

module gpip_div (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              advance,
   input  logic                                              in_valid,
   input  gpip_pkg::div_side_type                            in_side,
   input  logic [gpip_pkg::LANES-1:0][gpip_pkg::REM_W-1:0]   in_rem,
   output logic                                              out_valid,
   output gpip_pkg::div_side_type                            out_side,
   output logic [gpip_pkg::LANES-1:0][gpip_pkg::QUO_W-1:0]   out_quo,
   output logic [gpip_pkg::LANES-1:0]                        out_ovf
);
   import gpip_pkg::*;

   localparam int LAST = QUO_W;

   logic                          valid_ff [LAST+1];
   div_side_type                  side_ff  [LAST+1];
   logic [LANES-1:0][REM_W-1:0]   rem_ff   [LAST+1];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff   [LAST+1];
   logic [LANES-1:0]              ovf_ff   [LAST+1];

   for (genvar s = 0; s <= LAST; s++) begin : g_stage
      if (s == 0) begin : g_ovf
         logic [LANES-1:0] ovf_in;
         logic [CMP_W-1:0] limit;

         always_comb begin
            limit = CMP_W'(in_side.den) << QUO_W;
            for (int l = 0; l < LANES; l++) begin
               ovf_in[l] = CMP_W'(in_rem[l]) >= limit;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               side_ff[s] <= in_side;
               rem_ff[s]  <= in_rem;
               quo_ff[s]  <= '0;
               ovf_ff[s]  <= ovf_in;
            end
         end
      end else begin : g_bit
         localparam int K = QUO_W - s;

         logic [CMP_W-1:0]            shifted;
         logic [LANES-1:0]            ge;
         logic [LANES-1:0][REM_W-1:0] rem_in;
         logic [LANES-1:0][QUO_W-1:0] quo_in;

         always_comb begin
            shifted = CMP_W'(side_ff[s-1].den) << K;
            for (int l = 0; l < LANES; l++) begin
               ge[l]        = CMP_W'(rem_ff[s-1][l]) >= shifted;
               rem_in[l]    = ge[l] ? REM_W'(CMP_W'(rem_ff[s-1][l]) - shifted)
                                    : rem_ff[s-1][l];
               quo_in[l]    = quo_ff[s-1][l];
               quo_in[l][K] = ge[l];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               side_ff[s] <= side_ff[s-1];
               rem_ff[s]  <= rem_in;
               quo_ff[s]  <= quo_in;
               ovf_ff[s]  <= ovf_ff[s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_side  = side_ff[LAST];
   assign out_quo   = quo_ff[LAST];
   assign out_ovf   = ovf_ff[LAST];

endmodule

`default_nettype wire

// ----- rtl/gpip_back.sv -----
// Output stage: apply sign, add principal point, saturate to 24 bits, register result.
// Drives the result channel registers; depends on gpip_pkg.
`default_nettype none

module gpip_back (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              advance,
   input  gpip_pkg::cfg_type                                 cfg,
   input  logic                                              in_valid,
   input  gpip_pkg::div_side_type                            in_side,
   input  logic [gpip_pkg::LANES-1:0][gpip_pkg::QUO_W-1:0]   in_quo,
   input  logic [gpip_pkg::LANES-1:0]                        in_ovf,
   output logic                                              out_valid,
   output logic [gpip_pkg::OUT_W-1:0]                        out_col,
   output logic [gpip_pkg::OUT_W-1:0]                        out_row,
   output logic                                              out_ok
);
   import gpip_pkg::*;

   logic                    valid_ff;
   logic [OUT_W-1:0]        col_ff, col_in;
   logic [OUT_W-1:0]        row_ff, row_in;
   logic                    ok_ff;

   logic [QUO_W-1:0]        qc     [LANES];
   logic [CFG_W-1:0]        center [LANES];
   logic signed [SUM_W-1:0] sum    [LANES];
   logic [OUT_W-1:0]        pix    [LANES];

   always_comb begin
      center[LANE_COL] = cfg.center_x;
      center[LANE_ROW] = cfg.center_y;
      for (int l = 0; l < LANES; l++) begin
         // a quotient that does not fit saturates the sum either way
         qc[l]  = in_ovf[l] ? '1 : in_quo[l];
         sum[l] = in_side.neg[l] ? $signed(SUM_W'(center[l])) - $signed(SUM_W'(qc[l]))
                                 : $signed(SUM_W'(center[l])) + $signed(SUM_W'(qc[l]));
         if (!in_side.ok) begin
            pix[l] = '0;
         end else if (sum[l] > SAT_MAX) begin
            pix[l] = SAT_MAX[OUT_W-1:0];
         end else if (sum[l] < SAT_MIN) begin
            pix[l] = SAT_MIN[OUT_W-1:0];
         end else begin
            pix[l] = sum[l][OUT_W-1:0];
         end
      end
      col_in = pix[LANE_COL];
      row_in = pix[LANE_ROW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
         ok_ff  <= in_side.ok;
      end
   end

   assign out_valid = valid_ff;
   assign out_col   = col_ff;
   assign out_row   = row_ff;
   assign out_ok    = ok_ff;

endmodule

`default_nettype wire

// ----- rtl/ground_point_to_image_projection.sv -----
// Projects ground-plane points through a pitched pinhole camera to image column and row
// in 1/16 pixel. Top level: camera registers, handshake and the three pipeline parts.
// Depends on gpip_pkg, gpip_front, gpip_div and gpip_back.
//
// Usage: one point is accepted every clock while not stalled and one result leaves per
// point, in order. It has 7 geometry and dividend stages, 26 divider stages (an
// out-of-range check plus one quotient bit per stage of a restoring divider) and the
// output register. The whole pipeline freezes while a result is held on rsp_ and not
// taken, so req_tready is low only then. Points whose depth is below the minimum
// (MIN_DEPTH_UNITS, in 1/1024 m) return depth_ok (rsp_tuser) low and a zero pixel.
// Write camera registers only while no points are in flight; writes take effect at once.
`default_nettype none

module ground_point_to_image_projection #(
   parameter int MIN_DEPTH_UNITS = gpip_pkg::MIN_DEPTH_UNITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // input point
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,  // [23:0] ground_fwd, [47:24] ground_left
   // projected pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,  // [23:0] image_col, [47:24] image_row
   output logic                                rsp_tuser,  // [0] depth_ok
   // camera registers
   input  logic                                csr_we,
   input  logic [gpip_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [gpip_pkg::CFG_W-1:0]          csr_wdata
);
   import gpip_pkg::*;

   cfg_type cfg_ff;

   logic advance;

   logic                        fr_valid;
   div_side_type                fr_side;
   logic [LANES-1:0][REM_W-1:0] fr_rem;

   logic                        dv_valid;
   div_side_type                dv_side;
   logic [LANES-1:0][QUO_W-1:0] dv_quo;
   logic [LANES-1:0]            dv_ovf;

   logic [OUT_W-1:0]            out_col;
   logic [OUT_W-1:0]            out_row;
   logic                        out_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_PITCH_SIN:     cfg_ff.pitch_sin     <= csr_wdata;
            REG_PITCH_COS:     cfg_ff.pitch_cos     <= csr_wdata;
            REG_FOCAL_X:       cfg_ff.focal_x       <= csr_wdata;
            REG_FOCAL_Y:       cfg_ff.focal_y       <= csr_wdata;
            REG_CENTER_X:      cfg_ff.center_x      <= csr_wdata;
            REG_CENTER_Y:      cfg_ff.center_y      <= csr_wdata;
            REG_CAMERA_HEIGHT: cfg_ff.camera_height <= csr_wdata;
            REG_CAMERA_OFFSET: cfg_ff.camera_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold every stage while the output register is full and not taken
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   gpip_front #(
      .MIN_DEPTH_UNITS (MIN_DEPTH_UNITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_fwd    ($signed(req_tdata[IN_W-1:0])),
      .in_left   ($signed(req_tdata[2*IN_W-1:IN_W])),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_rem   (fr_rem)
   );

   gpip_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_rem    (fr_rem),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf)
   );

   gpip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_quo    (dv_quo),
      .in_ovf    (dv_ovf),
      .out_valid (rsp_tvalid),
      .out_col   (out_col),
      .out_row   (out_row),
      .out_ok    (out_ok)
   );

   assign rsp_tdata = {out_row, out_col};
   assign rsp_tuser = out_ok;

   // a point that fails the depth test carries a zero pixel
   a_bad_depth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("pixel not zeroed for a point below minimum depth");

   // a stalled output freezes the divider feed as well
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(fr_valid) && $stable(dv_valid))
      else $error("pipeline moved while output was stalled");

   // nothing leaves the block right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid directly after reset");

endmodule

`default_nettype wire
